[design/relk_pkg.sv]
// shared types, sizes and helpers for the ring entry offset lookup core
// no dependencies; imported by the core, its port checker and the testbench
package relk_pkg;

  localparam int RING_SLOTS = 16;
  localparam int SLOT_W     = $clog2(RING_SLOTS);
  localparam int CNT_W      = $clog2(RING_SLOTS + 1);

  localparam int HANDLE_W = 32;
  localparam int LEN_W    = 16;
  localparam int POS_W    = 20;
  localparam int HSLOT_W  = 4;

  // packed stream widths, padded to whole bytes
  localparam int IN_DATA_RAW_W  = HANDLE_W + LEN_W + POS_W;
  localparam int IN_DATA_W      = ((IN_DATA_RAW_W + 7) / 8) * 8;
  localparam int OUT_DATA_RAW_W = 1 + HANDLE_W + HSLOT_W + LEN_W + 1;
  localparam int OUT_DATA_W     = ((OUT_DATA_RAW_W + 7) / 8) * 8;

  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [HANDLE_W-1:0] handle_t;
  typedef logic [LEN_W-1:0]    len_t;
  typedef logic [POS_W-1:0]    pos_t;

  typedef enum logic {
    MODE_ADD  = 1'b0,
    MODE_FIND = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic    evicted_oldest;
    len_t    offset_in_entry;
    logic [HSLOT_W-1:0] hit_slot;
    handle_t hit_handle;
    logic    found;
  } result_t;

  function automatic slot_t next_slot(slot_t s);
    slot_t r;
    if (s == SLOT_W'(RING_SLOTS - 1)) begin
      r = '0;
    end else begin
      r = s + SLOT_W'(1);
    end
    return r;
  endfunction

  // low bits of a slot index as reported on the result
  function automatic logic [HSLOT_W-1:0] slot_field(slot_t s);
    logic [31:0] w;
    w = 32'(s);
    return w[HSLOT_W-1:0];
  endfunction

endpackage

[design/ring_entry_offset_lookup_core.sv]
// ring entry offset lookup: a ring of (handle, length) entries with an add
// operation that overwrites the oldest and a find walking byte offsets
// depends on relk_pkg
//
//  channel | signals                          | content
//  --------+----------------------------------+-------------------------------
//  input   | in_tvalid in_tready in_tdata     | tuser: mode; tdata: handle,
//          | in_tuser                         | length, byte position
//  output  | out_tvalid out_tready out_tdata  | found, hit handle, hit slot,
//          |                                  | offset in entry, evicted flag
//
// an add transaction goes from accept through ST_DONE into the output register
// a find walks the stored entries oldest first through the entry memory read
// port (address in ST_READ, then registered data in ST_CMP), up to RING_SLOTS
// one transaction at a time; in_tready is low from accept until the result
// is loaded into the output register, which holds while out_tready is low
// rst_n clears indexes, full flag and control; entry memory is not cleared
module ring_entry_offset_lookup_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [31:0] entry_handle, [47:32] entry_length, [67:48] byte_position, pad
  input  logic [relk_pkg::IN_DATA_W-1:0]  in_tdata,
  // [0] mode
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] found, [32:1] hit_handle, [36:33] hit_slot, [52:37] offset_in_entry,
  // [53] evicted_oldest, pad
  output logic [relk_pkg::OUT_DATA_W-1:0] out_tdata
);
  import relk_pkg::*;

  state_t  state_r, state_nxt;
  slot_t   wr_idx_r, wr_idx_nxt;
  slot_t   rd_idx_r, rd_idx_nxt;
  logic    full_r, full_nxt;
  slot_t   walk_idx_r, walk_idx_nxt;
  cnt_t    walk_cnt_r, walk_cnt_nxt;
  pos_t    pos_r, pos_nxt;
  result_t res_r, res_nxt;
  result_t out_res_r, out_res_nxt;
  logic    out_valid_r, out_valid_nxt;

  handle_t mem_handle [RING_SLOTS];
  len_t    mem_len    [RING_SLOTS];
  handle_t rd_handle_r;
  len_t    rd_len_r;

  handle_t in_handle;
  len_t    in_len;
  pos_t    in_pos;
  mode_t   in_mode;
  logic    in_acc;
  logic    add_acc;
  logic    out_free;
  cnt_t    used_cnt;
  slot_t   add_rd_idx;
  slot_t   add_wr_idx;
  logic    hit;

  assign in_handle = in_tdata[HANDLE_W-1:0];
  assign in_len    = in_tdata[HANDLE_W+LEN_W-1:HANDLE_W];
  assign in_pos    = in_tdata[HANDLE_W+LEN_W+POS_W-1:HANDLE_W+LEN_W];
  assign in_mode   = mode_t'(in_tuser);

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign add_acc   = in_acc && (in_mode == MODE_ADD);
  assign out_free  = !out_valid_r || out_tready;

  // entries currently held, oldest at rd_idx_r
  always_comb begin
    if (full_r) begin
      used_cnt = CNT_W'(RING_SLOTS);
    end else if (wr_idx_r >= rd_idx_r) begin
      used_cnt = CNT_W'(wr_idx_r - rd_idx_r);
    end else begin
      used_cnt = CNT_W'(CNT_W'(wr_idx_r) + CNT_W'(RING_SLOTS) - CNT_W'(rd_idx_r));
    end
  end

  assign add_rd_idx = full_r ? next_slot(rd_idx_r) : rd_idx_r;
  assign add_wr_idx = next_slot(wr_idx_r);
  assign hit        = (pos_r < POS_W'(rd_len_r));

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (add_acc) begin
      mem_handle[wr_idx_r] <= in_handle;
      mem_len[wr_idx_r]    <= in_len;
    end
    rd_handle_r <= mem_handle[walk_idx_r];
    rd_len_r    <= mem_len[walk_idx_r];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_mode == MODE_FIND && used_cnt != '0) begin
            state_nxt = ST_READ;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (hit || walk_cnt_r == CNT_W'(1)) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath and ring bookkeeping
  always_comb begin
    wr_idx_nxt    = wr_idx_r;
    rd_idx_nxt    = rd_idx_r;
    full_nxt      = full_r;
    walk_idx_nxt  = walk_idx_r;
    walk_cnt_nxt  = walk_cnt_r;
    pos_nxt       = pos_r;
    res_nxt       = res_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_nxt = '0;
          if (in_mode == MODE_ADD) begin
            res_nxt.hit_slot       = slot_field(wr_idx_r);
            res_nxt.evicted_oldest = full_r;
            rd_idx_nxt             = add_rd_idx;
            wr_idx_nxt             = add_wr_idx;
            full_nxt               = full_r || (add_wr_idx == add_rd_idx);
          end else begin
            walk_idx_nxt = rd_idx_r;
            walk_cnt_nxt = used_cnt;
            pos_nxt      = in_pos;
          end
        end
      end
      ST_CMP: begin
        if (hit) begin
          res_nxt.found           = 1'b1;
          res_nxt.hit_handle      = rd_handle_r;
          res_nxt.hit_slot        = slot_field(walk_idx_r);
          res_nxt.offset_in_entry = pos_r[LEN_W-1:0];
        end else begin
          pos_nxt      = pos_r - POS_W'(rd_len_r);
          walk_idx_nxt = next_slot(walk_idx_r);
          walk_cnt_nxt = walk_cnt_r - CNT_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_res_nxt   = res_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_idx_r    <= wr_idx_nxt;
      rd_idx_r    <= rd_idx_nxt;
      full_r      <= full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    walk_idx_r <= walk_idx_nxt;
    walk_cnt_r <= walk_cnt_nxt;
    pos_r      <= pos_nxt;
    res_r      <= res_nxt;
    out_res_r  <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_res_r);

endmodule

[design/relk_port_checker.sv]
// port-level checks for the ring entry offset lookup core
// depends on relk_pkg; bound to ring_entry_offset_lookup_core below
module relk_port_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [relk_pkg::OUT_DATA_W-1:0] out_tdata
);
  import relk_pkg::*;

  result_t res;
  assign res = out_tdata[OUT_DATA_RAW_W-1:0];

  // a stalled result transaction holds its data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // one transaction at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again before result produced");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !res.found |-> res.hit_handle == '0 && res.offset_in_entry == '0)
    else $error("miss carries nonzero handle or offset");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.found |-> !res.evicted_oldest)
    else $error("find result flags an eviction");

endmodule

bind ring_entry_offset_lookup_core relk_port_checker u_relk_port_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[test/testbench.sv]
// self-checking testbench for ring_entry_offset_lookup_core: add and find
// transactions checked against a ring predictor kept in the bench
// depends on relk_pkg and the core in design/
module testbench;
  import relk_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 2 + 2 * RING_SLOTS + 8;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  ring_entry_offset_lookup_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // predicted ring contents
  handle_t     ring_handle [RING_SLOTS];
  len_t        ring_len    [RING_SLOTS];
  int unsigned ring_wr;
  int unsigned ring_rd;
  bit          ring_is_full;

  result_t awaited_results[$];

  bit idle_on;
  int stall_left;
  int cycle_count;
  int n_mismatch;
  int n_adds, n_evicts, n_finds, n_hits;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned wrap_slot(int unsigned s);
    return (s + 1 >= RING_SLOTS) ? 0 : s + 1;
  endfunction

  function automatic int unsigned live_entries();
    return ring_is_full ? RING_SLOTS : (ring_wr + RING_SLOTS - ring_rd) % RING_SLOTS;
  endfunction

  function automatic int unsigned stored_bytes();
    int unsigned sum;
    int unsigned idx;
    sum = 0;
    idx = ring_rd;
    for (int unsigned k = 0; k < live_entries(); k++) begin
      sum += ring_len[idx];
      idx = wrap_slot(idx);
    end
    return sum;
  endfunction

  // updates the predicted ring and returns the result the transaction causes
  function automatic result_t advance_ring(mode_t m, handle_t h, len_t l, pos_t p);
    result_t     r;
    int unsigned cnt;
    int unsigned idx;
    pos_t        rem;
    bit          hit;
    r = '0;
    if (m == MODE_ADD) begin
      n_adds++;
      if (ring_is_full) begin
        ring_rd = wrap_slot(ring_rd);
        r.evicted_oldest = 1'b1;
        n_evicts++;
      end
      ring_handle[ring_wr] = h;
      ring_len[ring_wr]    = l;
      r.hit_slot = 4'(ring_wr);
      ring_wr = wrap_slot(ring_wr);
      if (ring_wr == ring_rd) ring_is_full = 1'b1;
    end else begin
      n_finds++;
      cnt = live_entries();
      idx = ring_rd;
      rem = p;
      hit = 1'b0;
      for (int unsigned k = 0; k < cnt && !hit; k++) begin
        if (rem < POS_W'(ring_len[idx])) begin
          hit = 1'b1;
          r.found           = 1'b1;
          r.hit_handle      = ring_handle[idx];
          r.hit_slot        = 4'(idx);
          r.offset_in_entry = rem[LEN_W-1:0];
        end else begin
          rem = rem - POS_W'(ring_len[idx]);
          idx = wrap_slot(idx);
        end
      end
      if (hit) n_hits++;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    n_mismatch++;
  endtask

  // one input transaction, with an optional idle burst ahead of it
  task automatic send_item(mode_t m, handle_t h, len_t l, pos_t p);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= m;
    in_tdata  <= IN_DATA_W'({p, l, h});
    do @(posedge clk); while (in_tready !== 1'b1);
    awaited_results.push_back(advance_ring(m, h, l, p));
  endtask

  task automatic send_add(handle_t h, len_t l);
    send_item(MODE_ADD, h, l, pos_t'($urandom));
  endtask

  task automatic send_find(pos_t p);
    send_item(MODE_FIND, handle_t'($urandom), len_t'($urandom), p);
  endtask

  function automatic len_t pick_length();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return '0;
      1: return '1;
      2: return len_t'($urandom);
      default: return len_t'($urandom_range(1, 64));
    endcase
  endfunction

  function automatic pos_t pick_position();
    int unsigned total;
    int r;
    total = stored_bytes();
    r = $urandom_range(0, 9);
    if (r == 0 || total == 0) return pos_t'($urandom);
    if (r == 1) return pos_t'(total);
    if (r == 2) return pos_t'(total - 1);
    return pos_t'($urandom_range(0, total - 1));
  endfunction

  task automatic test_empty_ring();
    send_find('0);
    send_find('1);
  endtask

  // max-size entry, zero-length entry that the walk must skip, one-byte entry
  task automatic test_entry_edges();
    send_add('1, '1);
    send_add('0, '0);
    send_add(32'h1234_5678, 16'd1);
    send_find('0);
    send_find(pos_t'(16'hffff));
    send_find(pos_t'(20'h1_0000));
    send_find('1);
  endtask

  // fill the ring up and add once more so the oldest is dropped
  task automatic test_wraparound();
    for (int i = 0; i < 14; i++) begin
      send_add(handle_t'($urandom), len_t'($urandom_range(0, 8)));
    end
    send_find(pos_t'(stored_bytes() - 1));
    send_find(pos_t'($urandom_range(0, stored_bytes() - 1)));
  endtask

  task automatic test_random_mix(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 45) begin
        send_add(handle_t'($urandom), pick_length());
      end else begin
        send_find(pick_position());
      end
    end
  endtask

  // output checker and sink-side backpressure
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = result_t'(out_tdata[$bits(result_t)-1:0]);
      if (awaited_results.size() == 0) begin
        report_mismatch("result with nothing awaited, hit_handle", got.hit_handle, '0);
      end else begin
        want = awaited_results.pop_front();
        if (got.found !== want.found)
          report_mismatch("found", 32'(got.found), 32'(want.found));
        if (got.hit_handle !== want.hit_handle)
          report_mismatch("hit_handle", got.hit_handle, want.hit_handle);
        if (got.hit_slot !== want.hit_slot)
          report_mismatch("hit_slot", 32'(got.hit_slot), 32'(want.hit_slot));
        if (got.offset_in_entry !== want.offset_in_entry)
          report_mismatch("offset_in_entry", 32'(got.offset_in_entry),
                          32'(want.offset_in_entry));
        if (got.evicted_oldest !== want.evicted_oldest)
          report_mismatch("evicted_oldest", 32'(got.evicted_oldest),
                          32'(want.evicted_oldest));
      end
    end
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still awaited", cycle_count,
               awaited_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    ring_wr      = 0;
    ring_rd      = 0;
    ring_is_full = 1'b0;
    idle_on      = 1'b1;
    stall_left   = 0;
    cycle_count  = 0;
    n_mismatch   = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= MODE_ADD;
    in_tdata  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_ring();
    test_entry_edges();
    test_wraparound();
    test_random_mix(535);
    // steady stream with no idling on either side
    idle_on = 1'b0;
    test_random_mix(40);
    in_tvalid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0) begin
      report_mismatch("results never arrived, count", 32'(awaited_results.size()), '0);
    end

    $display("ran %0d adds (%0d dropped the oldest entry) and %0d finds (%0d hits)",
             n_adds, n_evicts, n_finds, n_hits);
    $display("mismatches counted: %0d", n_mismatch);
    if (n_mismatch == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
